@@ design/bdq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

	// list geometry
	localparam int DEPTH       = 16;
	localparam int VALUE_WIDTH = 32;
	localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W       = $clog2(DEPTH + 1);

	// command queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// operation codes as carried on the item port
	typedef enum logic [2:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_DEL_VALUE  = 3'd4,
		OP_DEL_AFTER  = 3'd5,
		OP_DEL_BEFORE = 3'd6,
		OP_FIND       = 3'd7
	} op_t;

	// decoded command classes
	typedef enum logic [1:0] {
		K_PUSH,
		K_POP,
		K_DEL,
		K_FIND
	} kind_t;

	// which element a delete removes, relative to the first match
	typedef enum logic [1:0] {
		REL_AT,
		REL_AFTER,
		REL_BEFORE
	} rel_t;

	typedef struct packed {
		logic [2:0]        op;
		logic signed [31:0] value;
	} item_t;

	typedef struct packed {
		logic               accepted;
		logic [3:0]         match_position;
		logic signed [31:0] front_value;
		logic signed [31:0] back_value;
		logic [4:0]         count;
		logic               is_empty;
	} result_t;

	typedef struct packed {
		kind_t                  kind;
		logic                   at_front;
		rel_t                   rel;
		logic [VALUE_WIDTH-1:0] key;
	} cmd_t;

endpackage

`default_nettype wire

@@ design/bdq_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bdq_front (
	input  wire logic          start,
	input  wire bdq_pkg::item_t item,
	input  wire logic          q_full,
	output logic               busy,
	output logic               q_push,
	output bdq_pkg::cmd_t      q_cmd
);
	import bdq_pkg::*;

	op_t opc;

	// accept whenever the queue has room
	assign busy   = q_full;
	assign q_push = start & ~q_full;
	assign opc    = op_t'(item.op);

	// classify the operation and widen the key to the stored width
	always_comb begin
		q_cmd.kind     = K_FIND;
		q_cmd.at_front = 1'b0;
		q_cmd.rel      = REL_AT;
		q_cmd.key      = VALUE_WIDTH'(signed'(item.value));
		unique case (opc)
			OP_PUSH_FRONT: begin
				q_cmd.kind     = K_PUSH;
				q_cmd.at_front = 1'b1;
			end
			OP_PUSH_BACK: begin
				q_cmd.kind = K_PUSH;
			end
			OP_POP_FRONT: begin
				q_cmd.kind     = K_POP;
				q_cmd.at_front = 1'b1;
			end
			OP_POP_BACK: begin
				q_cmd.kind = K_POP;
			end
			OP_DEL_VALUE: begin
				q_cmd.kind = K_DEL;
			end
			OP_DEL_AFTER: begin
				q_cmd.kind = K_DEL;
				q_cmd.rel  = REL_AFTER;
			end
			OP_DEL_BEFORE: begin
				q_cmd.kind = K_DEL;
				q_cmd.rel  = REL_BEFORE;
			end
			OP_FIND: begin
				q_cmd.kind = K_FIND;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ design/bdq_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bdq_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire bdq_pkg::cmd_t push_cmd,
	input  wire logic          pop,
	output bdq_pkg::cmd_t      head_cmd,
	output logic               full,
	output logic               empty
);
	import bdq_pkg::*;

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W:0]   wr_q;
	logic [QPTR_W:0]   rd_q;

	// pointers carry one extra wrap bit to tell full from empty
	assign empty    = (wr_q == rd_q);
	assign full     = (wr_q[QPTR_W] != rd_q[QPTR_W]) &&
	                  (wr_q[QPTR_W-1:0] == rd_q[QPTR_W-1:0]);
	assign head_cmd = mem_q[rd_q[QPTR_W-1:0]];

	// pointer update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push && !full)
				wr_q <= wr_q + (QPTR_W+1)'(1);
			if (pop && !empty)
				rd_q <= rd_q + (QPTR_W+1)'(1);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push && !full)
			mem_q[wr_q[QPTR_W-1:0]] <= push_cmd;
	end

endmodule

`default_nettype wire

@@ design/bdq_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bdq_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire bdq_pkg::cmd_t head_cmd,
	input  wire logic          q_empty,
	output logic               q_pop,
	output logic               done,
	output bdq_pkg::result_t   result
);
	import bdq_pkg::*;

	typedef enum logic {
		S_MATCH,
		S_APPLY
	} state_t;

	state_t                 state_q;
	logic [VALUE_WIDTH-1:0] value_q [DEPTH];
	logic [DEPTH-1:0]       valid_q;
	logic [CNT_W-1:0]       cnt_q;

	cmd_t                   cmd_s1;
	logic                   found_s1;
	logic [IDX_W-1:0]       pos_s1;

	logic                   pend_q;
	logic                   acc_q;
	logic [3:0]             mpos_q;
	logic                   done_q;
	result_t                result_q;

	logic [DEPTH-1:0]       eq;
	logic [DEPTH-1:0]       first;
	logic                   found;
	logic [IDX_W-1:0]       pos;

	logic                   ok;
	logic                   do_drop;
	logic                   do_push_f;
	logic                   do_push_b;
	logic [IDX_W-1:0]       drop_pos;
	logic [IDX_W-1:0]       last_idx;
	logic [DEPTH-1:0]       therm;

	assign done   = done_q;
	assign result = result_q;
	assign q_pop  = (state_q == S_MATCH) && !q_empty;

	// key compare in every cell, first match wins
	always_comb begin
		for (int i = 0; i < DEPTH; i++)
			eq[i] = valid_q[i] && (value_q[i] == head_cmd.key);
		first = eq & (~eq + DEPTH'(1));
		found = |eq;
		pos   = '0;
		for (int i = 0; i < DEPTH; i++)
			if (first[i])
				pos = pos | IDX_W'(i);
	end

	// decide the update from the registered match
	assign last_idx = IDX_W'(cnt_q - CNT_W'(1));

	always_comb begin
		ok        = 1'b0;
		do_drop   = 1'b0;
		do_push_f = 1'b0;
		do_push_b = 1'b0;
		drop_pos  = '0;
		unique case (cmd_s1.kind)
			K_PUSH: begin
				ok        = (cnt_q != CNT_W'(DEPTH));
				do_push_f = ok && cmd_s1.at_front;
				do_push_b = ok && !cmd_s1.at_front;
			end
			K_POP: begin
				ok       = (cnt_q != '0);
				do_drop  = ok;
				drop_pos = cmd_s1.at_front ? '0 : last_idx;
			end
			K_DEL: begin
				unique case (cmd_s1.rel)
					REL_AFTER: begin
						ok       = found_s1 &&
						           ((CNT_W'(pos_s1) + CNT_W'(1)) < cnt_q);
						drop_pos = pos_s1 + IDX_W'(1);
					end
					REL_BEFORE: begin
						ok       = found_s1 && (pos_s1 != '0);
						drop_pos = pos_s1 - IDX_W'(1);
					end
					default: begin
						ok       = found_s1;
						drop_pos = pos_s1;
					end
				endcase
				do_drop = ok;
			end
			K_FIND: begin
				ok = found_s1;
			end
		endcase
	end

	// control, occupancy and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_MATCH;
			valid_q <= '0;
			cnt_q   <= '0;
			pend_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			// report the list as it stands after the last update
			if (pend_q) begin
				pend_q                  <= 1'b0;
				done_q                  <= 1'b1;
				result_q.accepted       <= acc_q;
				result_q.match_position <= mpos_q;
				result_q.count          <= 5'(cnt_q);
				result_q.is_empty       <= (cnt_q == '0);
				result_q.front_value    <= (cnt_q == '0) ? '0 :
				                           32'(signed'(value_q[0]));
				result_q.back_value     <= (cnt_q == '0) ? '0 :
				                           32'(signed'(value_q[last_idx]));
			end
			unique case (state_q)
				S_MATCH: begin
					if (!q_empty) begin
						cmd_s1   <= head_cmd;
						found_s1 <= found;
						pos_s1   <= pos;
						state_q  <= S_APPLY;
					end
				end
				S_APPLY: begin
					acc_q  <= ok;
					mpos_q <= 4'(pos_s1);
					pend_q <= 1'b1;
					if (do_push_f || do_push_b) begin
						valid_q[IDX_W'(cnt_q)] <= 1'b1;
						cnt_q                  <= cnt_q + CNT_W'(1);
					end else if (do_drop) begin
						valid_q[last_idx] <= 1'b0;
						cnt_q             <= cnt_q - CNT_W'(1);
					end
					state_q <= S_MATCH;
				end
			endcase
		end
	end

	// cell values: push front shifts towards the back, push back writes the
	// next free cell, a pop or delete moves the cells above the gap forward
	always_ff @(posedge clk) begin
		if (state_q == S_APPLY) begin
			if (do_push_f) begin
				value_q[0] <= cmd_s1.key;
				for (int i = 1; i < DEPTH; i++)
					value_q[i] <= value_q[i-1];
			end else if (do_push_b) begin
				value_q[IDX_W'(cnt_q)] <= cmd_s1.key;
			end else if (do_drop) begin
				for (int i = 0; i < DEPTH - 1; i++)
					if (IDX_W'(i) >= drop_pos)
						value_q[i] <= value_q[i+1];
			end
		end
	end

	// occupied cells always form a run from the front
	always_comb begin
		for (int i = 0; i < DEPTH; i++)
			therm[i] = (CNT_W'(i) < cnt_q);
	end

	a_valid_run: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q == therm)
		else $error("occupied cells do not match the element count");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("element count beyond depth");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_APPLY |=> (cnt_q == $past(cnt_q) ||
		                        cnt_q == $past(cnt_q) + CNT_W'(1) ||
		                        cnt_q == $past(cnt_q) - CNT_W'(1)))
		else $error("element count moved by more than one");

	a_done_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("two results in consecutive cycles");

	a_report_follows_apply: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == S_APPLY, 2))
		else $error("result without an update before it");

endmodule

`default_nettype wire

@@ design/bounded_deque_with_value_delete_core.sv @@
// Ordered list of up to DEPTH signed values with push/pop at both ends,
// delete by value (at, after or before the first match) and find. An item
// is taken at an edge where start is high and busy is low; it goes into a
// four-entry command queue, and busy stays high only while that queue is
// full. The back end of the list handles an item in the states S_MATCH,
// which compares the key against every cell and registers the first match,
// and S_APPLY, which shifts the cells and updates the count; it takes no
// new item from the queue until S_APPLY for the last one is done. The
// result is registered from the updated cells and done is high for one
// cycle; it must be taken in that cycle. match_position refers to the list
// before the operation and is 0 when there is no match.
`timescale 1ns / 1ps
`default_nettype none

module bounded_deque_with_value_delete_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire bdq_pkg::item_t  item,
	output logic                 done,
	output bdq_pkg::result_t     result
);
	import bdq_pkg::*;

	cmd_t push_cmd;
	cmd_t head_cmd;
	logic q_push;
	logic q_pop;
	logic q_full;
	logic q_empty;

	// accept and classify
	bdq_front u_front (
		.start  (start),
		.item   (item),
		.q_full (q_full),
		.busy   (busy),
		.q_push (q_push),
		.q_cmd  (push_cmd)
	);

	// command queue
	bdq_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.pop      (q_pop),
		.head_cmd (head_cmd),
		.full     (q_full),
		.empty    (q_empty)
	);

	// cell chain
	bdq_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_cmd (head_cmd),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.done     (done),
		.result   (result)
	);

endmodule

`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import bdq_pkg::*;

	localparam logic signed [31:0] VMAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] VMIN = 32'sh8000_0000;
	localparam int TOTAL_ITEMS = 1550;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 20;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    start;
	logic    busy;
	item_t   item;
	logic    done;
	result_t result;

	bounded_deque_with_value_delete_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	always #6 clk = ~clk;

	// one row of the directed plan; reps > 1 sends value, value+1, ...
	typedef struct {
		op_t              op;
		logic signed [31:0] value;
		int               reps;
		bit               typed;
		result_t          want;
	} step_t;

	step_t   plan[$];
	result_t expected_results[$];

	// shadow copy of the list, front at index 0
	logic signed [31:0] list_vals [DEPTH];
	int      list_len = 0;

	int      mismatches = 0;
	int      results_seen = 0;
	int      items_sent = 0;
	int      directed_items = 0;
	int      full_pushes = 0;
	int      empty_pops = 0;
	int      cycles = 0;
	result_t want_r;

	// remove one element, later ones close up towards the front
	function automatic void drop_element(input int pos);
		int j;
		for (j = pos; j + 1 < list_len; j++)
			list_vals[j] = list_vals[j + 1];
		list_len--;
	endfunction

	// apply one item to the shadow list and work out what the block reports
	function automatic result_t apply_to_list(input item_t it);
		result_t r;
		logic    hit;
		logic    ok;
		int      at;
		int      j;
		hit = 1'b0;
		ok  = 1'b0;
		at  = 0;
		for (j = 0; j < list_len; j++) begin
			if (!hit && list_vals[j] == it.value) begin
				hit = 1'b1;
				at  = j;
			end
		end
		case (op_t'(it.op))
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (list_len < DEPTH) begin
					if (op_t'(it.op) == OP_PUSH_FRONT) begin
						for (j = list_len; j > 0; j--)
							list_vals[j] = list_vals[j - 1];
						list_vals[0] = it.value;
					end else begin
						list_vals[list_len] = it.value;
					end
					list_len++;
					ok = 1'b1;
				end else begin
					full_pushes++;
				end
			end
			OP_POP_FRONT, OP_POP_BACK: begin
				if (list_len > 0) begin
					drop_element((op_t'(it.op) == OP_POP_FRONT) ? 0 : list_len - 1);
					ok = 1'b1;
				end else begin
					empty_pops++;
				end
			end
			OP_DEL_VALUE: begin
				if (hit) begin
					drop_element(at);
					ok = 1'b1;
				end
			end
			OP_DEL_AFTER: begin
				if (hit && at + 1 < list_len) begin
					drop_element(at + 1);
					ok = 1'b1;
				end
			end
			OP_DEL_BEFORE: begin
				if (hit && at > 0) begin
					drop_element(at - 1);
					ok = 1'b1;
				end
			end
			default: ok = hit;
		endcase
		r.accepted       = ok;
		r.match_position = hit ? 4'(at) : 4'd0;
		r.front_value    = (list_len > 0) ? list_vals[0] : 32'sd0;
		r.back_value     = (list_len > 0) ? list_vals[list_len - 1] : 32'sd0;
		r.count          = 5'(list_len);
		r.is_empty       = (list_len == 0);
		return r;
	endfunction

	// key mix: four in ten keys are values already held (if any), so deletes and finds hit
	function automatic logic signed [31:0] pick_key();
		int r;
		int t;
		r = $urandom_range(0, 9);
		if (r < 4 && list_len > 0)
			return list_vals[$urandom_range(0, list_len - 1)];
		if (r < 7) begin
			t = $urandom_range(0, 8);
			return t - 4;
		end
		if (r == 7)
			return ($urandom_range(0, 1) != 0) ? VMAX : VMIN;
		return $urandom;
	endfunction

	task automatic add_step(input op_t op, input logic signed [31:0] v, input int reps,
			input bit typed, input logic acc, input logic [3:0] pos,
			input logic signed [31:0] fr, input logic signed [31:0] bk,
			input logic [4:0] cnt);
		step_t st;
		st.op                  = op;
		st.value               = v;
		st.reps                = reps;
		st.typed               = typed;
		st.want.accepted       = acc;
		st.want.match_position = pos;
		st.want.front_value    = fr;
		st.want.back_value     = bk;
		st.want.count          = cnt;
		st.want.is_empty       = (cnt == 0);
		plan.push_back(st);
	endtask

	// present one item after a gap, wait for the handshake, record what is due
	task automatic send_item(input item_t it, input int gap, input bit typed,
			input result_t want);
		result_t got;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		item  <= it;
		do @(posedge clk); while (busy);
		got = apply_to_list(it);
		expected_results.push_back(typed ? want : got);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic check_field(input string fname, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		if (exp_v !== got_v) begin
			mismatches++;
			if (mismatches <= 10)
				$display("Mismatch on result %0d, %s: expected %h, got %h",
					results_seen, fname, exp_v, got_v);
		end
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && done) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result %0d with nothing pending", results_seen);
			end else begin
				want_r = expected_results.pop_front();
				check_field("accepted", 32'(want_r.accepted), 32'(result.accepted));
				check_field("match_position", 32'(want_r.match_position),
					32'(result.match_position));
				check_field("front_value", want_r.front_value, result.front_value);
				check_field("back_value", want_r.back_value, result.back_value);
				check_field("count", 32'(want_r.count), 32'(result.count));
				check_field("is_empty", 32'(want_r.is_empty), 32'(result.is_empty));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		item_t it;
		int    k;
		int    burst_len;
		int    mode;
		int    w;
		bit    steady;

		arst_n = 1'b0;
		start  = 1'b0;
		item   = '0;

		// every pop, delete and find on an empty list is turned away
		add_step(OP_POP_FRONT,  32'sd0, 1, 1, 1'b0, 4'd0, 32'sd0, 32'sd0, 5'd0);
		add_step(OP_POP_BACK,   32'sd0, 1, 1, 1'b0, 4'd0, 32'sd0, 32'sd0, 5'd0);
		add_step(OP_DEL_VALUE,  32'sd0, 1, 1, 1'b0, 4'd0, 32'sd0, 32'sd0, 5'd0);
		add_step(OP_DEL_AFTER,  32'sd0, 1, 1, 1'b0, 4'd0, 32'sd0, 32'sd0, 5'd0);
		add_step(OP_DEL_BEFORE, 32'sd0, 1, 1, 1'b0, 4'd0, 32'sd0, 32'sd0, 5'd0);
		add_step(OP_FIND,       32'sd0, 1, 1, 1'b0, 4'd0, 32'sd0, 32'sd0, 5'd0);
		// extremes at both ends
		add_step(OP_PUSH_BACK,  VMAX, 1, 1, 1'b1, 4'd0, VMAX, VMAX, 5'd1);
		add_step(OP_PUSH_FRONT, VMIN, 1, 1, 1'b1, 4'd0, VMIN, VMAX, 5'd2);
		add_step(OP_FIND,       VMAX, 1, 1, 1'b1, 4'd1, VMIN, VMAX, 5'd2);
		// nothing before the front, nothing after the back, key missing, delete before the back
		add_step(OP_DEL_BEFORE, VMIN, 1, 0, 1'b0, 4'd0, 32'sd0, 32'sd0, 5'd0);
		add_step(OP_DEL_AFTER,  VMAX, 1, 0, 1'b0, 4'd0, 32'sd0, 32'sd0, 5'd0);
		add_step(OP_DEL_VALUE,  32'sd99, 1, 0, 1'b0, 4'd0, 32'sd0, 32'sd0, 5'd0);
		add_step(OP_DEL_BEFORE, VMAX, 1, 0, 1'b0, 4'd0, 32'sd0, 32'sd0, 5'd0);
		// fill to the brim, push on a full list, then delete, find and pop on it
		add_step(OP_PUSH_BACK,  -32'sd8, 15, 0, 1'b0, 4'd0, 32'sd0, 32'sd0, 5'd0);
		add_step(OP_PUSH_FRONT, 32'sd1, 1, 0, 1'b0, 4'd0, 32'sd0, 32'sd0, 5'd0);
		add_step(OP_PUSH_BACK,  32'sh5555_AAAA, 1, 0, 1'b0, 4'd0, 32'sd0, 32'sd0, 5'd0);
		add_step(OP_DEL_AFTER,  VMAX, 1, 0, 1'b0, 4'd0, 32'sd0, 32'sd0, 5'd0);
		add_step(OP_FIND,       32'sd0, 1, 0, 1'b0, 4'd0, 32'sd0, 32'sd0, 5'd0);
		add_step(OP_POP_BACK,   32'sd0, 1, 0, 1'b0, 4'd0, 32'sd0, 32'sd0, 5'd0);
		add_step(OP_POP_FRONT,  32'sd0, 1, 0, 1'b0, 4'd0, 32'sd0, 32'sd0, 5'd0);
		add_step(OP_DEL_VALUE,  32'sd0, 1, 0, 1'b0, 4'd0, 32'sd0, 32'sd0, 5'd0);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed plan
		foreach (plan[s]) begin
			for (k = 0; k < plan[s].reps; k++) begin
				it.op    = plan[s].op;
				it.value = plan[s].value + k;
				send_item(it, $urandom_range(0, 10), plan[s].typed, plan[s].want);
			end
		end
		directed_items = items_sent;

		// random bursts: filling, draining or mixed, some with no gaps at all
		while (items_sent < TOTAL_ITEMS) begin
			burst_len = $urandom_range(8, 40);
			mode      = $urandom_range(0, 2);
			steady    = ($urandom_range(0, 3) == 0);
			for (k = 0; k < burst_len; k++) begin
				w = $urandom_range(0, 99);
				if (mode == 0 && w < 70)
					it.op = ($urandom_range(0, 1) != 0) ? OP_PUSH_FRONT : OP_PUSH_BACK;
				else if (mode == 1 && w < 60)
					it.op = 3'($urandom_range(OP_POP_FRONT, OP_DEL_BEFORE));
				else
					it.op = 3'($urandom_range(0, 7));
				it.value = pick_key();
				send_item(it, steady ? 0 : $urandom_range(0, 10), 1'b0, '0);
			end
		end
		start <= 1'b0;

		// drain, then give the block time to show anything stray
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d items (%0d directed), checked %0d results", items_sent,
			directed_items, results_seen);
		$display("Pushes onto a full list: %0d, pops from an empty list: %0d",
			full_pushes, empty_pops);
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Mismatches: %0d", mismatches);
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
